FILE: design/multilevel_feedback_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the feedback scheduler
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// implication checked on every edge outside reset
`define MFS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfs check failed");

// next-cycle implication
`define MFS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfs check failed");

`endif

FILE: design/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and constants of the feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int JOB_SLOTS = 16;
    localparam int SLOT_W    = $clog2(JOB_SLOTS);
    localparam int CNT_W     = $clog2(JOB_SLOTS + 1);

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ENQ  = 2'd1;
    localparam logic [1:0] FUNC_DEQ  = 2'd2;
    localparam logic [1:0] FUNC_DONE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] CFG_SLICE1 = 2'd0;
    localparam logic [1:0] CFG_SLICE2 = 2'd1;
    localparam logic [1:0] CFG_SLICE3 = 2'd2;
    localparam logic [1:0] CFG_AGING  = 2'd3;

    localparam logic [1:0] PRIO_TOP     = 2'd3;
    localparam logic [1:0] LEVEL_BOTTOM = 2'd3;
    localparam logic [7:0] WAIT_MAX     = 8'd255;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  priority_req;
        logic [15:0] job_id;
    } in_item_t;

    typedef struct packed {
        logic        running_valid;
        logic [15:0] running_id;
        logic [1:0]  served_level;
        logic [15:0] assigned_id;
        logic [1:0]  status;
        logic        switched;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  level;
        logic [1:0]  base_prio;
        logic [1:0]  cur_prio;
        logic [7:0]  wait_cnt;
        logic [15:0] order;
    } entry_t;

    typedef struct packed {
        logic [7:0] slice1;
        logic [7:0] slice2;
        logic [7:0] slice3;
        logic [7:0] aging;
    } cfg_t;

    // memory port bundle: one write, one read per cycle
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [1:0] drop_level(input logic [1:0] lvl);
        return (lvl < LEVEL_BOTTOM) ? lvl + 2'd1 : LEVEL_BOTTOM;
    endfunction

    function automatic logic [7:0] slice_for(input cfg_t c, input logic [1:0] lvl);
        logic [7:0] s;
        case (lvl)
            2'd1:    s = c.slice1;
            2'd2:    s = c.slice2;
            default: s = c.slice3;
        endcase
        return s;
    endfunction

endpackage

FILE: design/mfs_table.sv
// ----------------------------------------------------------------------------
// mfs_table
// Job table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfs_table
    import mfs_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [JOB_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

FILE: design/mfs_cfg.sv
// ----------------------------------------------------------------------------
// mfs_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module mfs_cfg
    import mfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{slice1: 8'd1, slice2: 8'd2, slice3: 8'd5, aging: 8'd10};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLICE1: cfg_reg.slice1 <= cfg_data;
                CFG_SLICE2: cfg_reg.slice2 <= cfg_data;
                CFG_SLICE3: cfg_reg.slice3 <= cfg_data;
                CFG_AGING:  cfg_reg.aging  <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: design/mfs_ctrl.sv
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer: aging pass, enqueue/dequeue, selection pass, write-back.
// ----------------------------------------------------------------------------
module mfs_ctrl
    import mfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output mem_req_t  mreq,
    input  entry_t    rdata,
    output logic      result_valid,
    output out_item_t result
);

`include "multilevel_feedback_scheduler_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AGE  = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_PRE  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;       // read address issue count
    logic                rv_reg, rv_next;         // rdata valid for slot rs_reg
    logic [SLOT_W-1:0]   rs_reg, rs_next;
    logic [JOB_SLOTS-1:0] valid_reg, valid_next;
    logic                run_on_reg, run_on_next;
    logic [SLOT_W-1:0]   run_slot_reg, run_slot_next;
    logic [15:0]         run_id_reg, run_id_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [7:0]          slice_reg, slice_next;
    logic [15:0]         idc_reg, idc_next;
    logic [15:0]         ordc_reg, ordc_next;
    in_item_t            item_reg, item_next;
    logic [1:0]          st_reg, st_next;
    logic [15:0]         asg_reg, asg_next;
    logic                sw_reg, sw_next;
    logic                forced_reg, forced_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic                best_on_reg, best_on_next;
    logic [SLOT_W-1:0]   best_slot_reg, best_slot_next;
    entry_t              best_reg, best_next;
    logic                out_v_reg, out_v_next;
    out_item_t           out_reg, out_next;

    logic                waiting;
    logic [15:0]         age_i, age_b;
    entry_t              e;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic                better;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = JOB_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rv_next       = 1'b0;
        rs_next       = rs_reg;
        valid_next    = valid_reg;
        run_on_next   = run_on_reg;
        run_slot_next = run_slot_reg;
        run_id_next   = run_id_reg;
        lvl_next      = lvl_reg;
        slice_next    = slice_reg;
        idc_next      = idc_reg;
        ordc_next     = ordc_reg;
        item_next     = item_reg;
        st_next       = st_reg;
        asg_next      = asg_reg;
        sw_next       = sw_reg;
        forced_next   = forced_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        best_on_next  = best_on_reg;
        best_slot_next = best_slot_reg;
        best_next     = best_reg;
        out_v_next    = 1'b0;
        out_next      = out_reg;
        mreq          = '0;
        e             = rdata;
        waiting       = valid_reg[rs_reg] && !(run_on_reg && run_slot_reg == rs_reg);
        age_i         = ordc_reg - rdata.order;
        age_b         = ordc_reg - best_reg.order;
        better        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    st_next     = ST_OK;
                    asg_next    = '0;
                    sw_next     = 1'b0;
                    forced_next = 1'b0;
                    hit_next    = 1'b0;
                    cnt_next    = '0;
                    if (item.func == FUNC_DONE)
                    begin
                        if (run_on_reg)
                        begin
                            valid_next[run_slot_reg] = 1'b0;
                            run_on_next = 1'b0;
                            sw_next     = 1'b1;
                            slice_next  = '0;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_AGE;
                    end
                end
            end

            // read each slot, age waiting slots of the served level and write them back; also look for dequeue hit
            S_AGE:
            begin
                if (cnt_reg < CNT_W'(JOB_SLOTS))
                begin
                    mreq.raddr = cnt_reg[SLOT_W-1:0];
                    rv_next    = 1'b1;
                    rs_next    = cnt_reg[SLOT_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (waiting && rdata.level == lvl_reg)
                    begin
                        if (e.wait_cnt < WAIT_MAX)
                        begin
                            e.wait_cnt = e.wait_cnt + 8'd1;
                        end
                        if (e.wait_cnt >= cfg.aging && e.cur_prio < PRIO_TOP)
                        begin
                            e.cur_prio = e.cur_prio + 2'd1;
                            e.wait_cnt = '0;
                        end
                        mreq.we    = 1'b1;
                        mreq.waddr = rs_reg;
                        mreq.wdata = e;
                    end
                    if (waiting && !hit_reg && rdata.id == item_reg.job_id)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = rs_reg;
                    end
                    if (rs_reg == SLOT_W'(JOB_SLOTS - 1))
                    begin
                        state_next = S_OP;
                    end
                end
            end

            S_OP:
            begin
                if (item_reg.func == FUNC_ENQ)
                begin
                    if (!free_found)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        idc_next   = idc_reg + 16'd1;
                        valid_next[free_slot] = 1'b1;
                        mreq.we    = 1'b1;
                        mreq.waddr = free_slot;
                        mreq.wdata = '{id: idc_reg + 16'd1, level: 2'd1,
                                       base_prio: item_reg.priority_req,
                                       cur_prio: item_reg.priority_req,
                                       wait_cnt: 8'd0, order: ordc_reg};
                        ordc_next   = ordc_reg + 16'd1;
                        asg_next    = idc_reg + 16'd1;
                        forced_next = 1'b1;
                    end
                end
                else if (item_reg.func == FUNC_DEQ)
                begin
                    if (run_on_reg && run_id_reg == item_reg.job_id)
                    begin
                        valid_next[run_slot_reg] = 1'b0;
                        run_on_next = 1'b0;
                        sw_next     = 1'b1;
                    end
                    else if (hit_reg)
                    begin
                        valid_next[hit_slot_reg] = 1'b0;
                    end
                    else
                    begin
                        st_next = ST_NOTFOUND;
                    end
                end
                if (!forced_next && slice_reg > 8'd1)
                begin
                    slice_next = slice_reg - 8'd1;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next     = '0;
                    best_on_next = 1'b0;
                    state_next   = S_SEL;
                end
            end

            S_SEL:
            begin
                if (cnt_reg < CNT_W'(JOB_SLOTS))
                begin
                    mreq.raddr = cnt_reg[SLOT_W-1:0];
                    rv_next    = 1'b1;
                    rs_next    = cnt_reg[SLOT_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (waiting)
                    begin
                        if (!best_on_reg)
                        begin
                            better = 1'b1;
                        end
                        else if (rdata.level != best_reg.level)
                        begin
                            better = rdata.level < best_reg.level;
                        end
                        else if (rdata.cur_prio != best_reg.cur_prio)
                        begin
                            better = rdata.cur_prio > best_reg.cur_prio;
                        end
                        else
                        begin
                            better = age_i > age_b;
                        end
                    end
                    if (better)
                    begin
                        best_on_next   = 1'b1;
                        best_slot_next = rs_reg;
                        best_next      = rdata;
                    end
                    if (rs_reg == SLOT_W'(JOB_SLOTS - 1))
                    begin
                        state_next = S_PRE;
                    end
                end
            end

            // fetch running entry for demotion or preemption write-back
            S_PRE:
            begin
                mreq.raddr = run_slot_reg;
                state_next = S_WB;
            end

            S_WB:
            begin
                e = rdata;
                if (!best_on_reg)
                begin
                    if (run_on_reg)
                    begin
                        e.level    = drop_level(rdata.level);
                        mreq.we    = 1'b1;
                        mreq.waddr = run_slot_reg;
                        mreq.wdata = e;
                        lvl_next   = e.level;
                        slice_next = slice_for(cfg, e.level);
                    end
                    else
                    begin
                        slice_next = '0;
                    end
                    state_next = S_DONE;
                end
                else if (run_on_reg)
                begin
                    e.cur_prio = rdata.base_prio;
                    e.wait_cnt = '0;
                    e.level    = drop_level(rdata.level);
                    e.order    = ordc_reg;
                    mreq.we    = 1'b1;
                    mreq.waddr = run_slot_reg;
                    mreq.wdata = e;
                    ordc_next  = ordc_reg + 16'd1;
                    run_on_next = 1'b0;
                    state_next = S_WB;
                end
                else
                begin
                    e          = best_reg;
                    e.wait_cnt = '0;
                    mreq.we    = 1'b1;
                    mreq.waddr = best_slot_reg;
                    mreq.wdata = e;
                    run_on_next   = 1'b1;
                    run_slot_next = best_slot_reg;
                    run_id_next   = best_reg.id;
                    lvl_next      = best_reg.level;
                    slice_next    = slice_for(cfg, best_reg.level);
                    sw_next       = 1'b1;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                out_v_next = 1'b1;
                out_next   = '{running_valid: run_on_reg,
                               running_id: run_on_reg ? run_id_reg : 16'd0,
                               served_level: lvl_reg,
                               assigned_id: asg_reg,
                               status: st_reg,
                               switched: sw_reg};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rv_reg     <= 1'b0;
            valid_reg  <= '0;
            run_on_reg <= 1'b0;
            lvl_reg    <= 2'd1;
            slice_reg  <= '0;
            idc_reg    <= '0;
            ordc_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rv_reg     <= rv_next;
            valid_reg  <= valid_next;
            run_on_reg <= run_on_next;
            lvl_reg    <= lvl_next;
            slice_reg  <= slice_next;
            idc_reg    <= idc_next;
            ordc_reg   <= ordc_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg        <= rs_next;
        run_slot_reg  <= run_slot_next;
        run_id_reg    <= run_id_next;
        item_reg      <= item_next;
        st_reg        <= st_next;
        asg_reg       <= asg_next;
        sw_reg        <= sw_next;
        forced_reg    <= forced_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        best_on_reg   <= best_on_next;
        best_slot_reg <= best_slot_next;
        best_reg      <= best_next;
        out_reg       <= out_next;
    end

    `MFS_ASSERT_IMP(a_run_valid, run_on_reg && state_reg == S_IDLE, valid_reg[run_slot_reg])
    `MFS_ASSERT_NXT(a_result_once, out_v_reg, !out_v_reg)
    `MFS_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `MFS_ASSERT_IMP(a_level_range, 1'b1, lvl_reg != 2'd0)

endmodule

FILE: design/multilevel_feedback_scheduler.sv
// A done item makes no pass over the job table; any other item makes one
// 16-entry aging pass, and a second selection pass if it reschedules.
// One item at a time; busy is high until the result strobe.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: no job runs, level 1 served, first tick selects; table content
// is undefined, valid bits cleared.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Three-level feedback job scheduler, one tick per item.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler
    import mfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   item,
    output logic       result_valid,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t     cfg;
    mem_req_t mreq;
    entry_t   rdata;

    mfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfs_table u_table (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    mfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg          (cfg),
        .mreq         (mreq),
        .rdata        (rdata),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: tb/sv/multilevel_feedback_scheduler_checker.sv
// ----------------------------------------------------------------------------
// Feedback scheduler checker
// Watches the item, result and register channels, tracks the scheduler state
// itself and compares every result with its own prediction, in order.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_checker
    import mfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_item_t   item,
    input  logic       result_valid,
    input  out_item_t  result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  sl1, sl2, sl3, age_lim;
    logic        slot_on [JOB_SLOTS];
    logic [15:0] slot_id [JOB_SLOTS];
    logic [1:0]  slot_lvl [JOB_SLOTS];
    logic [1:0]  slot_base [JOB_SLOTS];
    logic [1:0]  slot_cur [JOB_SLOTS];
    logic [7:0]  slot_wait [JOB_SLOTS];
    logic [15:0] slot_ord [JOB_SLOTS];
    logic        job_running;
    int          run_slot;
    logic [1:0]  lvl_srv;
    logic [7:0]  slice_left;
    logic [15:0] id_ctr, ord_ctr;
    out_item_t   expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [7:0] level_slice(logic [1:0] l);
        if (l == 2'd1) return sl1;
        if (l == 2'd2) return sl2;
        return sl3;
    endfunction

    function automatic logic [1:0] lower_level(logic [1:0] l);
        return (l < LEVEL_BOTTOM) ? l + 2'd1 : LEVEL_BOTTOM;
    endfunction

    function automatic bit waiting(int i);
        return slot_on[i] && !(job_running && run_slot == i);
    endfunction

    function automatic logic [15:0] age(int i);
        return ord_ctr - slot_ord[i];
    endfunction

    function automatic bit pick_next();
        int best;
        best = JOB_SLOTS;
        for (int i = 0; i < JOB_SLOTS; i++) begin
            if (!waiting(i)) continue;
            if (best == JOB_SLOTS) begin
                best = i;
                continue;
            end
            if (slot_lvl[i] != slot_lvl[best]) begin
                if (slot_lvl[i] < slot_lvl[best]) best = i;
            end else if (slot_cur[i] != slot_cur[best]) begin
                if (slot_cur[i] > slot_cur[best]) best = i;
            end else if (age(i) > age(best)) begin
                best = i;
            end
        end
        if (best == JOB_SLOTS) begin
            if (job_running) begin
                slot_lvl[run_slot] = lower_level(slot_lvl[run_slot]);
                lvl_srv = slot_lvl[run_slot];
                slice_left = level_slice(lvl_srv);
            end else begin
                slice_left = 8'd0;
            end
            return 1'b0;
        end
        if (job_running) begin
            slot_cur[run_slot] = slot_base[run_slot];
            slot_wait[run_slot] = 8'd0;
            slot_lvl[run_slot] = lower_level(slot_lvl[run_slot]);
            slot_ord[run_slot] = ord_ctr;
            ord_ctr = ord_ctr + 16'd1;
        end
        job_running = 1'b1;
        run_slot = best;
        slot_wait[best] = 8'd0;
        lvl_srv = slot_lvl[best];
        slice_left = level_slice(lvl_srv);
        return 1'b1;
    endfunction

    function automatic out_item_t schedule_step(in_item_t it);
        out_item_t o;
        bit forced, sw;
        int slot, hit;
        o = '0;
        forced = 1'b0;
        sw = 1'b0;
        if (it.func == FUNC_DONE) begin
            if (job_running) begin
                slot_on[run_slot] = 1'b0;
                job_running = 1'b0;
                sw = 1'b1;
                slice_left = 8'd0;
            end
        end else begin
            for (int i = 0; i < JOB_SLOTS; i++) begin
                if (!waiting(i) || slot_lvl[i] != lvl_srv) continue;
                if (slot_wait[i] < WAIT_MAX) slot_wait[i] = slot_wait[i] + 8'd1;
                if (slot_wait[i] >= age_lim && slot_cur[i] < PRIO_TOP) begin
                    slot_cur[i] = slot_cur[i] + 2'd1;
                    slot_wait[i] = 8'd0;
                end
            end
            if (it.func == FUNC_ENQ) begin
                slot = JOB_SLOTS;
                for (int i = 0; i < JOB_SLOTS; i++)
                    if (!slot_on[i]) begin
                        slot = i;
                        break;
                    end
                if (slot == JOB_SLOTS) begin
                    o.status = ST_FULL;
                end else begin
                    id_ctr = id_ctr + 16'd1;
                    slot_on[slot] = 1'b1;
                    slot_id[slot] = id_ctr;
                    slot_lvl[slot] = 2'd1;
                    slot_base[slot] = it.priority_req;
                    slot_cur[slot] = it.priority_req;
                    slot_wait[slot] = 8'd0;
                    slot_ord[slot] = ord_ctr;
                    ord_ctr = ord_ctr + 16'd1;
                    o.assigned_id = id_ctr;
                    forced = 1'b1;
                end
            end else if (it.func == FUNC_DEQ) begin
                if (job_running && slot_id[run_slot] == it.job_id) begin
                    slot_on[run_slot] = 1'b0;
                    job_running = 1'b0;
                    sw = 1'b1;
                end else begin
                    hit = JOB_SLOTS;
                    for (int i = 0; i < JOB_SLOTS; i++)
                        if (waiting(i) && slot_id[i] == it.job_id) begin
                            hit = i;
                            break;
                        end
                    if (hit == JOB_SLOTS) o.status = ST_NOTFOUND;
                    else slot_on[hit] = 1'b0;
                end
            end
            if (!forced && slice_left > 8'd1) slice_left = slice_left - 8'd1;
            else if (pick_next()) sw = 1'b1;
        end
        o.running_valid = job_running;
        o.running_id = job_running ? slot_id[run_slot] : 16'd0;
        o.served_level = lvl_srv;
        o.switched = sw;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t e;
        if (!rst_n) begin
            sl1 <= 8'd1;
            sl2 <= 8'd2;
            sl3 <= 8'd5;
            age_lim <= 8'd10;
            for (int i = 0; i < JOB_SLOTS; i++) slot_on[i] = 1'b0;
            job_running = 1'b0;
            run_slot = 0;
            lvl_srv = 2'd1;
            slice_left = 8'd0;
            id_ctr = 16'd0;
            ord_ctr = 16'd0;
            fail_count <= 0;
            checked_count <= 0;
            expected_q.delete();
        end else begin
            if (result_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    checked_count <= checked_count + 1;
                    if (result !== e) begin
                        fail_count <= fail_count + 1;
                        if (result.running_valid !== e.running_valid)
                            $error("running_valid exp %0d got %0d",
                                   e.running_valid, result.running_valid);
                        if (result.running_id !== e.running_id)
                            $error("running_id exp %0d got %0d",
                                   e.running_id, result.running_id);
                        if (result.served_level !== e.served_level)
                            $error("served_level exp %0d got %0d",
                                   e.served_level, result.served_level);
                        if (result.assigned_id !== e.assigned_id)
                            $error("assigned_id exp %0d got %0d",
                                   e.assigned_id, result.assigned_id);
                        if (result.status !== e.status)
                            $error("status exp %0d got %0d", e.status, result.status);
                        if (result.switched !== e.switched)
                            $error("switched exp %0d got %0d",
                                   e.switched, result.switched);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(schedule_step(item));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLICE1: sl1 <= cfg_data;
                    CFG_SLICE2: sl2 <= cfg_data;
                    CFG_SLICE3: sl3 <= cfg_data;
                    default:    age_lim <= cfg_data;
                endcase
            end
        end
    end

endmodule

FILE: tb/sv/multilevel_feedback_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Feedback scheduler testbench
// Directed ticks, enqueues up to a full table, dequeues and done events,
// then random traffic over several slice and aging settings and idle modes.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_tb;
    import mfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   item;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count, pending, checked_count;
    int         idle_pct;
    logic [15:0] last_id;

    multilevel_feedback_scheduler DUT (.*);

    multilevel_feedback_scheduler_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge clk)
        if (result_valid && result.assigned_id != 16'd0) last_id <= result.assigned_id;

    task automatic send(logic [1:0] f, logic [1:0] p, logic [15:0] id);
        start <= 1'b1;
        item <= '{func: f, priority_req: p, job_id: id};
        while (busy) @(negedge clk);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            item <= '{func: 2'($urandom), priority_req: 2'($urandom),
                      job_id: 16'($urandom)};
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        while (!cfg_ready) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(logic [7:0] s1, logic [7:0] s2, logic [7:0] s3, logic [7:0] ag);
        drain();
        write_reg(CFG_SLICE1, s1);
        write_reg(CFG_SLICE2, s2);
        write_reg(CFG_SLICE3, s3);
        write_reg(CFG_AGING, ag);
    endtask

    task automatic random_items(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 40) send(FUNC_TICK, 2'($urandom), 16'($urandom));
            else if (r < 65) send(FUNC_ENQ, 2'($urandom), 16'($urandom));
            else if (r < 85) begin
                if ($urandom_range(9) < 8)
                    send(FUNC_DEQ, 2'($urandom), last_id - 16'($urandom_range(15)));
                else send(FUNC_DEQ, 2'($urandom), 16'($urandom));
            end else send(FUNC_DONE, 2'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLICE1;
        cfg_data = 8'd0;
        idle_pct = 0;
        last_id = 16'd0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(FUNC_TICK, 2'd0, 16'd0);
        send(FUNC_DONE, 2'd3, 16'hFFFF);
        send(FUNC_DEQ, 2'd0, 16'hFFFF);
        send(FUNC_ENQ, 2'd3, 16'h0000);
        send(FUNC_ENQ, 2'd0, 16'hFFFF);
        send(FUNC_ENQ, 2'd1, 16'h5555);
        send(FUNC_ENQ, 2'd2, 16'hAAAA);
        send(FUNC_TICK, 2'd0, 16'd0);
        send(FUNC_TICK, 2'd0, 16'd0);
        send(FUNC_DEQ, 2'd0, 16'd1);
        send(FUNC_DEQ, 2'd0, 16'd2);
        send(FUNC_DONE, 2'd0, 16'd0);
        for (int k = 0; k < 15; k++) send(FUNC_ENQ, k[1:0], 16'd0);
        send(FUNC_DONE, 2'd0, 16'd0);

        set_regs(8'd255, 8'd255, 8'd255, 8'd255);
        idle_pct = 0;
        random_items(160);
        set_regs(8'd1, 8'd1, 8'd1, 8'd1);
        idle_pct = 86;
        random_items(160);
        set_regs(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                 8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
        idle_pct = 10;
        random_items(160);
        set_regs(8'd1, 8'd2, 8'd5, 8'd10);
        idle_pct = 0;
        random_items(160);
        drain();

        $display("Covered %0d results: ticks, enqueues to full table, dequeues, done events,",
                 checked_count);
        $display("over four slice/aging settings and three sender idle modes.");
        if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
